// ----- rtl/core/stable_priority_queue_macros.svh -----
// ----------------------------------------------------------------------------
// Stable priority queue assertion macros
// Shared concurrent assertion forms for the queue checker.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

// ----- rtl/core/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue package
// Opcodes, status codes and the cell control word.
// ----------------------------------------------------------------------------
package spq_pkg;

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_DRAIN = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Broadcast to every cell: insert a new pair, or shift toward the front.
  typedef struct packed {
    logic ins;
    logic pop;
  } spq_ctrl_t;

endpackage

// ----- rtl/core/spq_if.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_in_if #(
  parameter int DATA_WIDTH = 32,
  parameter int PRIO_WIDTH = 8
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            op;
  logic [DATA_WIDTH-1:0] payload;
  logic [PRIO_WIDTH-1:0] priority_req;

  modport source (output valid, output op, output payload, output priority_req,
                  input ready);
  modport sink   (input valid, input op, input payload, input priority_req,
                  output ready);
endinterface

interface spq_out_if #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
);
  localparam int CntW = $clog2(DEPTH + 1);

  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] data_out;
  logic                  data_valid;
  logic [1:0]            status;
  logic [CntW-1:0]       occupancy;
  logic                  last;

  modport source (output valid, output data_out, output data_valid, output status,
                  output occupancy, output last, input ready);
  modport sink   (input valid, input data_out, input data_valid, input status,
                  input occupancy, input last, output ready);
endinterface

// ----- rtl/core/stable_priority_queue.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue
// Bounded sorted queue, highest priority first, FIFO among equal priorities.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one request transaction: op (enqueue, dequeue, peek, drain),
//   payload and priority_req. out_o returns result transactions with
//   data_out, data_valid, status, occupancy and last.
//   Enqueue, dequeue and peek give one result each, registered: it shows on
//   out_o the cycle after the request is taken. While the receiver keeps
//   ready high and no drain runs, a new request is taken every cycle.
//   Drain of N > 0 entries first records N with no result, then returns one
//   entry per cycle while the output slot is free, front first; in_i is held
//   off (ready low) until the last one is out.
//   The rate is set by the cell chain: every cell decides combinationally
//   and all move together, so insert and remove keep pace at any depth.
//   Reset clears the entry count, drain flag and output valid flag; cell
//   contents are not cleared, since only cells below the count are ever read.
//   When the receiver stalls, the result holds in the output register and
//   no new request is taken until that result is accepted.
// ----------------------------------------------------------------------------
module stable_priority_queue import spq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int PRIO_WIDTH = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  localparam int CntW = $clog2(DEPTH + 1);

  // Cell chain wiring
  logic [DATA_WIDTH-1:0] pay_w  [DEPTH];
  logic [PRIO_WIDTH-1:0] prio_w [DEPTH];
  logic                  ge_w   [DEPTH];
  logic                  occ_w  [DEPTH];
  spq_ctrl_t             ctrl;

  // Control and count
  logic [CntW-1:0] count_q, count_d;
  logic            drain_q, drain_d;
  logic [CntW-1:0] total_q, total_d;

  // Output register
  logic                  ovalid_q, ovalid_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  dvalid_q, dvalid_d;
  status_e               status_q, status_d;
  logic [CntW-1:0]       occ_q, occ_d;
  logic                  last_q, last_d;

  logic slot_free, acc, empty, full, drain_last;

  assign slot_free  = !ovalid_q || out_o.ready;
  assign in_i.ready = !drain_q && slot_free;
  assign acc        = in_i.valid && in_i.ready;
  assign empty      = (count_q == '0);
  assign full       = (count_q == CntW'(DEPTH));
  assign drain_last = (count_q == CntW'(1));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_pay, right_pay;
    logic [PRIO_WIDTH-1:0] left_prio, right_prio;
    logic                  left_ge;

    assign occ_w[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      // The front cell has nothing ahead of it.
      assign left_pay  = in_i.payload;
      assign left_prio = in_i.priority_req;
      assign left_ge   = 1'b1;
    end else begin : g_body
      assign left_pay  = pay_w[i-1];
      assign left_prio = prio_w[i-1];
      assign left_ge   = ge_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_pay  = pay_w[i];
      assign right_prio = prio_w[i];
    end else begin : g_mid
      assign right_pay  = pay_w[i+1];
      assign right_prio = prio_w[i+1];
    end

    spq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .PRIO_WIDTH (PRIO_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (occ_w[i]),
      .new_pay_i    (in_i.payload),
      .new_prio_i   (in_i.priority_req),
      .left_pay_i   (left_pay),
      .left_prio_i  (left_prio),
      .left_ge_i    (left_ge),
      .right_pay_i  (right_pay),
      .right_prio_i (right_prio),
      .ge_o         (ge_w[i]),
      .pay_o        (pay_w[i]),
      .prio_o       (prio_w[i])
    );
  end

  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    drain_d  = drain_q;
    total_d  = total_q;
    ovalid_d = ovalid_q && !out_o.ready;
    data_d   = data_q;
    dvalid_d = dvalid_q;
    status_d = status_q;
    occ_d    = occ_q;
    last_d   = last_q;

    if (drain_q && slot_free) begin
      // One drained entry per cycle from the front, while the output slot is free.
      ctrl.pop = 1'b1;
      count_d  = count_q - CntW'(1);
      drain_d  = !drain_last;
      ovalid_d = 1'b1;
      data_d   = pay_w[0];
      dvalid_d = 1'b1;
      status_d = ST_OK;
      occ_d    = drain_last ? total_q : (count_q - CntW'(1));
      last_d   = drain_last;
    end else if (acc) begin
      ovalid_d = 1'b1;
      data_d   = '0;
      dvalid_d = 1'b0;
      status_d = ST_OK;
      occ_d    = count_q;
      last_d   = 1'b1;
      case (op_e'(in_i.op))
        OP_ENQ: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + CntW'(1);
            occ_d    = count_q + CntW'(1);
          end
        end
        OP_DEQ: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.pop = 1'b1;
            count_d  = count_q - CntW'(1);
            data_d   = pay_w[0];
            dvalid_d = 1'b1;
            occ_d    = count_q - CntW'(1);
          end
        end
        OP_PEEK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            data_d   = pay_w[0];
            dvalid_d = 1'b1;
          end
        end
        OP_DRAIN: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            // Setup cycle: no result yet, remember the drained count.
            ovalid_d = ovalid_q && !out_o.ready;
            drain_d  = 1'b1;
            total_d  = count_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      drain_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      drain_q  <= drain_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q  <= total_d;
    data_q   <= data_d;
    dvalid_q <= dvalid_d;
    status_q <= status_d;
    occ_q    <= occ_d;
    last_q   <= last_d;
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.data_out   = data_q;
  assign out_o.data_valid = dvalid_q;
  assign out_o.status     = status_q;
  assign out_o.occupancy  = occ_q;
  assign out_o.last       = last_q;

endmodule

// ----- rtl/core/spq_cell.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue cell
// One slot of the sorted chain; takes the new pair, its neighbor or holds.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int PRIO_WIDTH = 8
) (
  input  logic                  clk_i,
  input  spq_ctrl_t             ctrl_i,
  input  logic                  occupied_i,
  input  logic [DATA_WIDTH-1:0] new_pay_i,
  input  logic [PRIO_WIDTH-1:0] new_prio_i,
  input  logic [DATA_WIDTH-1:0] left_pay_i,
  input  logic [PRIO_WIDTH-1:0] left_prio_i,
  input  logic                  left_ge_i,
  input  logic [DATA_WIDTH-1:0] right_pay_i,
  input  logic [PRIO_WIDTH-1:0] right_prio_i,
  output logic                  ge_o,
  output logic [DATA_WIDTH-1:0] pay_o,
  output logic [PRIO_WIDTH-1:0] prio_o
);

  logic [DATA_WIDTH-1:0] pay_q, pay_d;
  logic [PRIO_WIDTH-1:0] prio_q, prio_d;

  // Ties stay ahead of the new pair: that keeps equal priorities FIFO.
  assign ge_o = occupied_i && (prio_q >= new_prio_i);

  always_comb begin
    pay_d  = pay_q;
    prio_d = prio_q;
    if (ctrl_i.ins) begin
      if (!ge_o) begin
        if (left_ge_i) begin
          pay_d  = new_pay_i;
          prio_d = new_prio_i;
        end else begin
          pay_d  = left_pay_i;
          prio_d = left_prio_i;
        end
      end
    end else if (ctrl_i.pop) begin
      pay_d  = right_pay_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q  <= pay_d;
    prio_q <= prio_d;
  end

  assign pay_o  = pay_q;
  assign prio_o = prio_q;

endmodule

// ----- rtl/core/spq_checker.sv -----
// ----------------------------------------------------------------------------
// Stable priority queue checker
// Port-level checks on result transactions, bound to the top level.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_macros.svh"

module spq_checker import spq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [DATA_WIDTH-1:0]          data_out,
  input logic                           data_valid,
  input logic [1:0]                     status,
  input logic [$clog2(DEPTH+1)-1:0]     occupancy,
  input logic                           last
);

  // A result that carries no entry shows a zero word.
  `SPQ_ASSERT_IMP(a_zero_data, clk_i, rst_ni, out_valid && !data_valid, data_out == '0)

  // An entry is only returned with status ok.
  `SPQ_ASSERT_IMP(a_data_ok, clk_i, rst_ni, out_valid && data_valid, status == ST_OK)

  // Empty results are single and final, and report zero entries.
  `SPQ_ASSERT_IMP(a_empty_res, clk_i, rst_ni, out_valid && (status == ST_EMPTY),
                  last && (occupancy == '0))

  // A stalled result transaction holds.
  `SPQ_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, out_valid && !out_ready,
                  out_valid && $stable(data_out) && $stable(status) && $stable(last))

endmodule

bind stable_priority_queue spq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_spq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .data_out   (out_o.data_out),
  .data_valid (out_o.data_valid),
  .status     (out_o.status),
  .occupancy  (out_o.occupancy),
  .last       (out_o.last)
);
